// ===== hw/rtl/four_level_page_walk_top_defines.svh =====
// Assertion macros used by the page walker top level.
`ifndef FOUR_LEVEL_PAGE_WALK_TOP_DEFINES_SVH
`define FOUR_LEVEL_PAGE_WALK_TOP_DEFINES_SVH

// Implication in the same cycle, sampled on clk, off during reset.
`define PW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page walk check failed");

// Implication in the next cycle, sampled on clk, off during reset.
`define PW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page walk check failed");

`endif

// ===== hw/rtl/fpw_pkg.sv =====
`default_nettype none

package fpw_pkg;

  localparam int TABLE_FRAMES      = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int FRAME_W           = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int STORE_DEPTH       = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam int STORE_AW          = FRAME_W + IDX_W;
  localparam int ENTRY_W           = 64;
  localparam int PADDR_W           = 52;
  localparam int PFN_W             = 40;
  localparam int VADDR_W           = 48;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 52;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b1;

  typedef enum logic {
    ACT_WRITE     = 1'b0,
    ACT_TRANSLATE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_ROOT     = 2'd1,
    ST_OUTSIDE     = 2'd2,
    ST_NOT_PRESENT = 2'd3
  } status_e;

  typedef struct packed {
    action_e               action;
    logic [VADDR_W-1:0]    virt_addr;
    logic [5:0]            entry_frame;
    logic [IDX_W-1:0]      entry_index;
    logic [ENTRY_W-1:0]    entry_data;
  } in_item_t;

  typedef struct packed {
    logic [PADDR_W-1:0]    phys_addr;
    status_e               status;
    logic [2:0]            stop_level;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [STORE_AW-1:0]   addr;
    logic [ENTRY_W-1:0]    wdata;
  } store_req_t;

  typedef struct packed {
    logic                  clearing;
    logic                  walking;
    logic [2:0]            level;
  } walk_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fpw_ram.sv =====
`default_nettype none

module fpw_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fpw_walk.sv =====
`default_nettype none

module fpw_walk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fpw_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fpw_pkg::out_item_t           out_item,
  input  logic [fpw_pkg::PADDR_W-1:0]  root_table_addr,
  input  logic [fpw_pkg::PFN_W-1:0]    table_base_frame,
  output fpw_pkg::store_req_t          store_req,
  input  logic [fpw_pkg::ENTRY_W-1:0]  store_rdata,
  output fpw_pkg::walk_status_t        status
);
  import fpw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] rel;
  } frame_chk_t;

  state_t              state;
  state_t              state_next;
  logic [2:0]          level;
  logic [2:0]          level_next;
  logic [VADDR_W-1:0]  va;
  logic                clearing;
  logic [STORE_AW-1:0] clr_addr;
  out_item_t           hold;
  logic                fin;
  out_item_t           fin_res;
  frame_chk_t          chk;
  logic                out_free;
  logic                out_load;

  // Locate a table frame inside the store.
  function automatic frame_chk_t frame_check(input logic [PFN_W-1:0] frame,
                                             input logic [PFN_W-1:0] base);
    frame_chk_t       r;
    logic [PFN_W-1:0] diff;
    diff  = frame - base;
    r.ok  = (frame >= base) && (diff < PFN_W'(TABLE_FRAMES));
    r.rel = diff[FRAME_W-1:0];
    return r;
  endfunction

  // Table index for a level.
  function automatic logic [IDX_W-1:0] level_idx(input logic [VADDR_W-1:0] v,
                                                  input logic [2:0] lvl);
    logic [IDX_W-1:0] r;
    unique case (lvl)
      3'd4:    r = v[47:39];
      3'd3:    r = v[38:30];
      3'd2:    r = v[29:21];
      default: r = v[20:12];
    endcase
    return r;
  endfunction

  assign in_ready = (state == S_IDLE) && !clearing;
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && (fin || (state == S_HOLD));

  assign status.clearing = clearing;
  assign status.walking  = (state == S_WALK);
  assign status.level    = level;

  always_comb begin
    fin        = 1'b0;
    fin_res    = '0;
    state_next = state;
    level_next = level;
    chk        = '0;
    store_req  = '0;
    if (clearing) begin
      store_req.we   = 1'b1;
      store_req.addr = clr_addr;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_item.action == ACT_WRITE) begin
              store_req.we    = (32'(in_item.entry_frame) < TABLE_FRAMES);
              store_req.addr  = {FRAME_W'(in_item.entry_frame), in_item.entry_index};
              store_req.wdata = in_item.entry_data;
              fin             = 1'b1;
            end else if (root_table_addr[51:12] == '0) begin
              fin                = 1'b1;
              fin_res.status     = ST_NO_ROOT;
              fin_res.stop_level = 3'd4;
            end else begin
              chk = frame_check(root_table_addr[51:12], table_base_frame);
              if (!chk.ok) begin
                fin                = 1'b1;
                fin_res.status     = ST_OUTSIDE;
                fin_res.stop_level = 3'd4;
              end else begin
                store_req.addr = {chk.rel, level_idx(in_item.virt_addr, 3'd4)};
                level_next     = 3'd4;
                state_next     = S_WALK;
              end
            end
          end
        end
        S_WALK: begin
          if (!store_rdata[0]) begin
            fin                = 1'b1;
            fin_res.status     = ST_NOT_PRESENT;
            fin_res.stop_level = level;
          end else if (level == 3'd2 && store_rdata[7]) begin
            fin                = 1'b1;
            fin_res.phys_addr  = {store_rdata[51:21], va[20:0]};
            fin_res.stop_level = 3'd2;
          end else if (level == 3'd1) begin
            fin                = 1'b1;
            fin_res.phys_addr  = {store_rdata[51:12], va[11:0]};
            fin_res.stop_level = 3'd1;
          end else begin
            chk = frame_check(store_rdata[51:12], table_base_frame);
            if (!chk.ok) begin
              fin                = 1'b1;
              fin_res.status     = ST_OUTSIDE;
              fin_res.stop_level = level - 3'd1;
            end else begin
              store_req.addr = {chk.rel, level_idx(va, level - 3'd1)};
              level_next     = level - 3'd1;
            end
          end
        end
        S_HOLD: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      level     <= 3'd0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == STORE_AW'(STORE_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
      // Load a new result, or drop the current one once it transfers.
      out_valid <= out_load || (out_valid && !out_ready);
      level <= level_next;
      if (state == S_IDLE && in_valid && !clearing) begin
        va <= in_item.virt_addr;
      end
      if (fin) begin
        if (out_free) begin
          out_item  <= fin_res;
          state     <= S_IDLE;
        end else begin
          hold  <= fin_res;
          state <= S_HOLD;
        end
      end else if (state == S_HOLD) begin
        if (out_free) begin
          out_item  <= hold;
          state     <= S_IDLE;
        end
      end else begin
        state <= state_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/four_level_page_walk_top.sv =====
`default_nettype none
// Four-level page table walker with an internal entry store.
// Input channel (in_valid/in_ready/in_item): a write item sets one 64-bit entry
// of the store; a translate item walks levels 4..1 starting at the root register.
// Output channel (out_valid/out_ready/out_item): one result per item, in order.
// Config port (cfg_we/cfg_index/cfg_data): index 0 root table address,
// index 1 physical frame of store page 0; write only while the walker is idle.
// Timing: a write transfer finishes in its accept cycle, so writes go at one
// per cycle while the output is not stalled. A translation's accept cycle issues
// the level-4 read; each walk step consumes one registered store read and issues
// the next, and no new item is taken until the walk ends. Faults, and a level-2
// entry with bit 7 set, end the walk early. The final result is registered into
// out_item if the output is free. A result held by a stalled receiver stays in
// the output register while the next item is taken; a second finished result
// then waits in a hold stage and in_ready drops until the first transfer happens.
// Reset: clears registers, then sweeps the store to zero at one entry a cycle
// (TABLE_FRAMES * 512 entries, 32768 by default) with in_ready low; config
// writes are taken during the sweep.

`include "four_level_page_walk_top_defines.svh"

module four_level_page_walk_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fpw_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fpw_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  logic [fpw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fpw_pkg::*;

  logic [PADDR_W-1:0] root_table_addr;
  logic [PFN_W-1:0]   table_base_frame;
  store_req_t         store_req;
  logic [ENTRY_W-1:0] store_rdata;
  walk_status_t       walk_st;

  // Config registers: hold until written.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_addr  <= '0;
      table_base_frame <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROOT: root_table_addr  <= cfg_data;
        CFG_BASE: table_base_frame <= cfg_data[PFN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Entry store: one port, registered read.
  fpw_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (STORE_AW)
  ) u_store (
    .clk   (clk),
    .we    (store_req.we),
    .addr  (store_req.addr),
    .wdata (store_req.wdata),
    .rdata (store_rdata)
  );

  // Walk sequencer and output stage.
  fpw_walk u_walk (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item),
    .root_table_addr  (root_table_addr),
    .table_base_frame (table_base_frame),
    .store_req        (store_req),
    .store_rdata      (store_rdata),
    .status           (walk_st)
  );

  // No transfer is taken while the store sweep runs.
  `PW_ASSERT_NOW(a_no_accept_clearing, walk_st.clearing, !in_ready)
  // The walk level stays between 1 and 4 during a walk.
  `PW_ASSERT_NOW(a_level_range, walk_st.walking,
    (walk_st.level != 3'd0) && (walk_st.level <= 3'd4))
  // Outside the sweep, the store is written only by a write transfer.
  `PW_ASSERT_NOW(a_write_source, store_req.we && !walk_st.clearing,
    in_valid && in_ready && (in_item.action == ACT_WRITE))
  // The sweep runs on until its last entry.
  `PW_ASSERT_NEXT(a_sweep_runs,
    walk_st.clearing && (store_req.addr != STORE_AW'(STORE_DEPTH - 1)),
    walk_st.clearing)

endmodule

`default_nettype wire
